### hw/rtl/tcmc_pkg.sv
// tcmc_pkg: shared types, constants and codes for the timed cover motor controller
// no dependencies

package tcmc_pkg;

    localparam int COVER_COUNT_DEF = 4;
    localparam int TIME_BITS_DEF   = 24;
    localparam int TRAVEL_W        = 25;
    localparam int LEARN_W         = 24;
    localparam int PCT_W           = 7;
    localparam int ADDR_W          = 4;

    localparam logic [15:0] SECURE_RST = 16'd1000;
    localparam logic [23:0] OVERRUN_RST = 24'd60000;
    localparam logic [15:0] PERIOD_RST = 16'd250;
    localparam logic [23:0] FULL_RST = 24'd30000;

    localparam logic [ADDR_W-1:0] REG_SECURE  = 4'd0;
    localparam logic [ADDR_W-1:0] REG_OVERRUN = 4'd4;
    localparam logic [ADDR_W-1:0] REG_PERIOD  = 4'd8;

    typedef enum logic [2:0] {
        FN_TICK = 3'd0, FN_MOVE = 3'd1, FN_STOP = 3'd2, FN_CAL_START = 3'd3,
        FN_CAL_END = 3'd4, FN_BACKUP = 3'd5, FN_RESTORE = 3'd6, FN_NOP = 3'd7
    } func_t;

    typedef enum logic [2:0] {
        ST_CLOSED = 3'd0, ST_OPEN = 3'd1, ST_STOPPED = 3'd2,
        ST_OPENING = 3'd3, ST_CLOSING = 3'd4
    } cstat_t;

    typedef enum logic [4:0] {
        S_STOPPED, S_STOPPING, S_DELAY_START, S_START, S_UP, S_OVER_UP, S_DOWN,
        S_OVER_DOWN, S_CAL_DELAY_UP, S_CAL_DELAY_DOWN, S_CAL_UP, S_CAL_DOWN,
        S_CAL_OPENING, S_CAL_CLOSING, S_CAL_END, S_BK_DELAY, S_BK, S_BK_UP, S_BK_DOWN
    } step_t;

    typedef enum logic [3:0] {
        Q_IDLE, Q_LOAD, Q_DIV_E, Q_DIVW_E, Q_EXEC, Q_DIV_P1, Q_DIVW_P1, Q_POST,
        Q_DIV_P2, Q_DIVW_P2, Q_FINAL, Q_OUT, Q_DIV_D, Q_DIVW_D
    } seq_t;

    typedef struct packed {
        logic start;
        logic busy;
    } div_ctl_t;

endpackage

### hw/rtl/timed_cover_motor_controller.sv
// timed_cover_motor_controller: top level, per-cover state, sequencer, apb registers
// depends on tcmc_pkg and tcmc_div
//
// channel | direction | handshake      | payload
// in      | in        | in_valid/stall | cover_index func target_percent calibrate_up
// out     | out       | out_valid/stall| out_cover up_drive down_drive percent_open ...
// cfg     | in        | apb            | secure_delay_ms overrun_ms report_period_ms
//
// each transaction makes three passes of the shared bit-serial divider: one for the
// period check and two for the position percent before and after the update; a tick
// while closing adds a fourth pass for descent scaling; a cover index past the count
// skips the divider; output stalls hold the result in the output register, and the
// sequencer returns to idle between transactions
// reset returns every cover to stopped with learned times of 30000 ms
// the input stalls while a transaction is in work or its result waits in the
// output register

module timed_cover_motor_controller
    import tcmc_pkg::*;
#(
    parameter int COVER_COUNT = COVER_COUNT_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            cover_index,
    input  logic [2:0]            func,
    input  logic [PCT_W-1:0]      target_percent,
    input  logic                  calibrate_up,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            out_cover,
    output logic                  up_drive,
    output logic                  down_drive,
    output logic [PCT_W-1:0]      percent_open,
    output logic [2:0]            cover_status,
    output logic                  report_event,
    output logic                  save_request,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [tcmc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    localparam int CI_W  = (COVER_COUNT > 1) ? $clog2(COVER_COUNT) : 1;
    localparam int NUM_W = 56;
    localparam logic [TIME_BITS-1:0] EL_MAX = '1;
    localparam logic [TRAVEL_W-1:0] TR_MAX = '1;

    // configuration registers
    logic [15:0] secure_reg;
    logic [23:0] overrun_reg;
    logic [15:0] period_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            secure_reg  <= SECURE_RST;
            overrun_reg <= OVERRUN_RST;
            period_reg  <= PERIOD_RST;
        end
        else if (wr_en)
        begin
            case (paddr)
                REG_SECURE:  secure_reg  <= pwdata[15:0];
                REG_OVERRUN: overrun_reg <= pwdata[23:0];
                REG_PERIOD:  period_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            REG_SECURE:  prdata = {16'd0, secure_reg};
            REG_OVERRUN: prdata = {8'd0, overrun_reg};
            REG_PERIOD:  prdata = {16'd0, period_reg};
            default:     prdata = '0;
        endcase
    end

    // per-cover state
    step_t                step_q   [COVER_COUNT];
    logic [TRAVEL_W-1:0]  travel_q [COVER_COUNT];
    logic [TRAVEL_W-1:0]  origin_q [COVER_COUNT];
    logic [TIME_BITS-1:0] elap_q   [COVER_COUNT];
    logic [PCT_W-1:0]     goal_q   [COVER_COUNT];
    logic [LEARN_W-1:0]   fup_q    [COVER_COUNT];
    logic [LEARN_W-1:0]   fdn_q    [COVER_COUNT];
    logic [PCT_W-1:0]     saved_q  [COVER_COUNT];
    logic [1:0]           drv_q    [COVER_COUNT];

    // working copy of the addressed cover
    seq_t                 seq_reg, seq_next;
    logic [CI_W-1:0]      ci_reg;
    logic [1:0]           cov_reg;
    func_t                fn_reg;
    logic [PCT_W-1:0]     tgt_reg;
    logic                 cup_reg;
    logic                 skip_reg;
    step_t                st_reg, st_w;
    logic [TRAVEL_W-1:0]  tr_reg, tr_w;
    logic [TRAVEL_W-1:0]  or_reg, or_w;
    logic [TIME_BITS-1:0] el_reg, el_w;
    logic [PCT_W-1:0]     gl_reg, gl_w;
    logic [LEARN_W-1:0]   fu_reg, fu_w;
    logic [LEARN_W-1:0]   fd_reg, fd_w;
    logic [PCT_W-1:0]     sv_reg, sv_w;
    logic [1:0]           dr_reg, dr_w;
    logic                 ev_reg, ev_w;
    cstat_t               rst_reg, rst_w;
    logic                 save_reg, save_w;
    logic [PCT_W-1:0]     pct_reg;
    logic                 wb_en;

    // divider
    logic             dv_start;
    logic [NUM_W-1:0] dv_num, dv_quot;
    logic [LEARN_W-1:0] dv_den;
    logic             dv_busy;
    div_ctl_t         dctl;

    assign dctl.start = dv_start;
    assign dctl.busy  = dv_busy;

    tcmc_div #(.NUM_W(NUM_W), .DEN_W(LEARN_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (dv_num),
        .den   (dv_den),
        .busy  (dv_busy),
        .quot  (dv_quot)
    );

    // periodic check: e mod period, done by repeated subtraction over cycles is too slow,
    // so reuse the divider result (quotient times period compared with e)
    logic [NUM_W-1:0] per_q_reg;
    logic [15:0]      per_eff;
    assign per_eff = (period_reg == 16'd0) ? 16'd1 : period_reg;

    // percent from travel, clamp cases handled outside the divider
    function automatic logic pct_trivial(input logic [TRAVEL_W-1:0] t,
                                         input logic [LEARN_W-1:0] f);
        pct_trivial = (t == '0) || (t >= {1'b0, f});
    endfunction

    function automatic logic [PCT_W-1:0] pct_trivial_val(input logic [TRAVEL_W-1:0] t);
        pct_trivial_val = (t == '0) ? PCT_W'(0) : PCT_W'(100);
    endfunction

    logic [PCT_W-1:0] p_cur;
    logic [PCT_W-1:0] p_reg;

    // sequencer states
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= Q_IDLE;
        end
        else
        begin
            seq_reg <= seq_next;
        end
    end

    assign in_stall  = (seq_reg != Q_IDLE);
    assign out_valid = (seq_reg == Q_OUT);

    logic accept;
    assign accept = in_valid && !in_stall;

    // div period result check for periodic reporting
    logic [TIME_BITS+15:0] per_prod;
    logic                  is_periodic;
    assign per_prod    = per_q_reg[TIME_BITS-1:0] * per_eff;
    assign is_periodic = (per_prod == {16'd0, el_reg});

    always_comb
    begin
        seq_next = seq_reg;
        dv_start = 1'b0;
        dv_num   = '0;
        dv_den   = fu_reg;
        st_w = st_reg; tr_w = tr_reg; or_w = or_reg; el_w = el_reg; gl_w = gl_reg;
        fu_w = fu_reg; fd_w = fd_reg; sv_w = sv_reg; dr_w = dr_reg;
        ev_w = ev_reg; rst_w = rst_reg; save_w = save_reg;
        wb_en = 1'b0;
        p_cur = pct_trivial(tr_reg, fu_reg) ? pct_trivial_val(tr_reg)
              : PCT_W'(dv_quot);
        case (seq_reg)
            Q_IDLE:
            begin
                if (accept)
                begin
                    seq_next = Q_LOAD;
                end
            end
            Q_LOAD:
            begin
                if (skip_reg)
                begin
                    seq_next = Q_OUT;
                end
                else
                begin
                    // tick pre-work: bump elapsed, then go to the period division
                    if (fn_reg == FN_TICK)
                    begin
                        if (el_reg != EL_MAX)
                        begin
                            el_w = el_reg + 1'b1;
                        end
                    end
                    seq_next = Q_DIV_E;
                end
            end
            Q_DIV_E:
            begin
                // e / period for the periodic report check
                dv_start = 1'b1;
                dv_num   = NUM_W'(el_reg);
                dv_den   = {8'd0, per_eff};
                seq_next = Q_DIVW_E;
            end
            Q_DIVW_E:
            begin
                if (!dv_busy)
                begin
                    if (fn_reg == FN_TICK && (st_reg == S_DOWN || st_reg == S_BK_DOWN))
                    begin
                        seq_next = Q_DIV_D;
                    end
                    else
                    begin
                        seq_next = Q_DIV_P1;
                    end
                end
            end
            Q_DIV_D:
            begin
                // descent scaling: e * full_up / full_down
                dv_start = 1'b1;
                dv_num   = NUM_W'(el_reg) * NUM_W'(fu_reg);
                dv_den   = fd_reg;
                seq_next = Q_DIVW_D;
            end
            Q_DIVW_D:
            begin
                if (!dv_busy)
                begin
                    seq_next = Q_DIV_P1;
                end
            end
            Q_DIV_P1:
            begin
                // descent or ascent travel update before the position division
                if (fn_reg == FN_TICK && (st_reg == S_DOWN || st_reg == S_BK_DOWN))
                begin
                    if (fd_reg == '0)
                    begin
                        tr_w = '0;
                    end
                    else if (dv_quot < NUM_W'(or_reg))
                    begin
                        tr_w = or_reg - TRAVEL_W'(dv_quot);
                    end
                    else
                    begin
                        tr_w = '0;
                    end
                end
                else if (fn_reg == FN_TICK && (st_reg == S_UP || st_reg == S_BK_UP))
                begin
                    if ({1'b0, or_reg} + (TRAVEL_W+1)'(el_reg) > {1'b0, TR_MAX})
                    begin
                        tr_w = TR_MAX;
                    end
                    else
                    begin
                        tr_w = TRAVEL_W'({1'b0, or_reg} + (TRAVEL_W+1)'(el_reg));
                    end
                end
                seq_next = Q_DIVW_P1;
            end
            Q_DIVW_P1:
            begin
                // percent of the (possibly updated) travel
                dv_start = 1'b1;
                dv_num   = NUM_W'(tr_reg) * NUM_W'(100);
                dv_den   = fu_reg;
                seq_next = Q_EXEC;
            end
            Q_EXEC:
            begin
                if (!dv_busy)
                begin
                    seq_next = Q_POST;
                    case (fn_reg)
                        FN_TICK:
                        begin
                            case (st_reg)
                                S_DELAY_START, S_CAL_DELAY_UP, S_CAL_DELAY_DOWN, S_BK_DELAY:
                                begin
                                    dr_w = 2'b00;
                                    el_w = '0;
                                    st_w = (st_reg == S_DELAY_START) ? S_START
                                         : (st_reg == S_CAL_DELAY_UP) ? S_CAL_UP
                                         : (st_reg == S_CAL_DELAY_DOWN) ? S_CAL_DOWN : S_BK;
                                end
                                S_START, S_BK:
                                begin
                                    if ({8'd0, el_reg} > 32'(secure_reg))
                                    begin
                                        if (gl_reg == 7'd100 || gl_reg > p_cur)
                                        begin
                                            dr_w = 2'b01; el_w = '0; or_w = tr_reg;
                                            st_w = (st_reg == S_START) ? S_UP : S_BK_UP;
                                            ev_w = 1'b1; rst_w = ST_OPENING;
                                        end
                                        else if (gl_reg == 7'd0 || gl_reg < p_cur)
                                        begin
                                            dr_w = 2'b10; el_w = '0; or_w = tr_reg;
                                            st_w = (st_reg == S_START) ? S_DOWN : S_BK_DOWN;
                                            ev_w = 1'b1; rst_w = ST_CLOSING;
                                        end
                                        else
                                        begin
                                            st_w = S_STOPPING;
                                        end
                                    end
                                end
                                S_UP, S_BK_UP:
                                begin
                                    if (p_cur >= gl_reg)
                                    begin
                                        if (gl_reg >= 7'd100)
                                        begin
                                            tr_w = {1'b0, fu_reg}; el_w = '0;
                                            st_w = S_OVER_UP; ev_w = 1'b1; rst_w = ST_OPEN;
                                        end
                                        else
                                        begin
                                            dr_w = dr_reg & 2'b10;
                                            if (st_reg == S_BK_UP)
                                            begin
                                                st_w = S_DELAY_START; gl_w = sv_reg;
                                            end
                                            else
                                            begin
                                                st_w = S_STOPPED;
                                            end
                                            ev_w = 1'b1; rst_w = ST_STOPPED;
                                        end
                                    end
                                    else if (is_periodic)
                                    begin
                                        ev_w = 1'b1; rst_w = ST_OPENING;
                                    end
                                end
                                S_DOWN, S_BK_DOWN:
                                begin
                                    if (p_cur <= gl_reg)
                                    begin
                                        if (p_cur == '0)
                                        begin
                                            tr_w = '0; el_w = '0;
                                            st_w = S_OVER_DOWN; ev_w = 1'b1; rst_w = ST_CLOSED;
                                        end
                                        else
                                        begin
                                            dr_w = dr_reg & 2'b01;
                                            if (st_reg == S_BK_DOWN)
                                            begin
                                                st_w = S_DELAY_START; gl_w = sv_reg;
                                            end
                                            else
                                            begin
                                                st_w = S_STOPPED;
                                            end
                                            ev_w = 1'b1; rst_w = ST_STOPPED;
                                        end
                                    end
                                    else if (is_periodic)
                                    begin
                                        ev_w = 1'b1; rst_w = ST_CLOSING;
                                    end
                                end
                                S_OVER_UP, S_OVER_DOWN:
                                begin
                                    if ({8'd0, el_reg} >= 32'(overrun_reg))
                                    begin
                                        dr_w = 2'b00; st_w = S_STOPPED;
                                    end
                                end
                                S_CAL_UP, S_CAL_DOWN:
                                begin
                                    if (gl_reg == ((st_reg == S_CAL_UP) ? 7'd100 : 7'd0)
                                        && {8'd0, el_reg} > 32'(secure_reg))
                                    begin
                                        dr_w = (st_reg == S_CAL_UP) ? 2'b01 : 2'b10;
                                        el_w = '0;
                                        or_w = (st_reg == S_CAL_UP) ? TRAVEL_W'(0)
                                                                     : TRAVEL_W'(100);
                                        gl_w = 7'd50;
                                        st_w = (st_reg == S_CAL_UP) ? S_CAL_OPENING
                                                                     : S_CAL_CLOSING;
                                        ev_w = 1'b1;
                                        rst_w = (st_reg == S_CAL_UP) ? ST_OPENING : ST_CLOSING;
                                    end
                                end
                                S_CAL_OPENING:
                                begin
                                    fu_w = ({8'd0, el_reg} > 32'hFF_FFFF) ? '1
                                         : LEARN_W'(el_reg);
                                end
                                S_CAL_CLOSING:
                                begin
                                    fd_w = ({8'd0, el_reg} > 32'hFF_FFFF) ? '1
                                         : LEARN_W'(el_reg);
                                end
                                S_CAL_END, S_STOPPING:
                                begin
                                    dr_w = 2'b00;
                                    save_w = (st_reg == S_CAL_END);
                                    st_w = S_STOPPED;
                                    ev_w = 1'b1; rst_w = ST_STOPPED;
                                end
                                default: ;
                            endcase
                        end
                        FN_MOVE:
                        begin
                            gl_w = (tgt_reg > 7'd100) ? 7'd100 : tgt_reg;
                            st_w = S_DELAY_START;
                        end
                        FN_STOP:
                        begin
                            st_w = S_STOPPING;
                        end
                        FN_CAL_START:
                        begin
                            st_w = cup_reg ? S_CAL_DELAY_UP : S_CAL_DELAY_DOWN;
                            gl_w = cup_reg ? 7'd100 : 7'd0;
                        end
                        FN_CAL_END:
                        begin
                            if (st_reg == S_CAL_OPENING || st_reg == S_CAL_CLOSING)
                            begin
                                st_w = S_CAL_END;
                            end
                        end
                        FN_BACKUP:
                        begin
                            sv_w = p_cur;
                            save_w = 1'b1;
                            gl_w = (p_cur <= 7'd50) ? p_cur + 7'd5 : p_cur - 7'd5;
                            st_w = S_BK_DELAY;
                        end
                        FN_RESTORE:
                        begin
                            if (p_cur != sv_reg)
                            begin
                                gl_w = sv_reg; st_w = S_DELAY_START;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            Q_POST:
            begin
                // final percent after the update
                dv_start = 1'b1;
                dv_num   = NUM_W'(tr_reg) * NUM_W'(100);
                dv_den   = fu_reg;
                seq_next = Q_DIV_P2;
            end
            Q_DIV_P2:
            begin
                seq_next = Q_DIVW_P2;
            end
            Q_DIVW_P2:
            begin
                if (!dv_busy)
                begin
                    seq_next = Q_FINAL;
                end
            end
            Q_FINAL:
            begin
                wb_en    = 1'b1;
                seq_next = Q_OUT;
            end
            Q_OUT:
            begin
                if (!out_stall)
                begin
                    seq_next = Q_IDLE;
                end
            end
            default:
            begin
                seq_next = Q_IDLE;
            end
        endcase
    end

    // derived status of the cover after the transaction
    cstat_t dstate;
    always_comb
    begin
        case (st_reg)
            S_STOPPED, S_STOPPING, S_CAL_END, S_OVER_UP, S_OVER_DOWN:
                dstate = (p_reg == '0) ? ST_CLOSED
                       : (p_reg == 7'd100) ? ST_OPEN : ST_STOPPED;
            S_DELAY_START, S_START:
                dstate = (p_reg < gl_reg) ? ST_OPENING : ST_CLOSING;
            S_UP, S_CAL_DELAY_UP, S_CAL_UP:
                dstate = ST_OPENING;
            S_DOWN, S_CAL_DELAY_DOWN, S_CAL_DOWN:
                dstate = ST_CLOSING;
            default:
                dstate = ST_STOPPED;
        endcase
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cov_reg  <= cover_index;
            ci_reg   <= CI_W'(cover_index);
            fn_reg   <= func_t'(func);
            tgt_reg  <= target_percent;
            cup_reg  <= calibrate_up;
            skip_reg <= (32'(cover_index) >= 32'(COVER_COUNT));
            ev_reg   <= 1'b0;
            rst_reg  <= ST_STOPPED;
            save_reg <= 1'b0;
        end
        else if (seq_reg == Q_LOAD && !skip_reg)
        begin
            st_reg <= step_q[ci_reg];
            tr_reg <= travel_q[ci_reg];
            or_reg <= origin_q[ci_reg];
            // a tick advances elapsed time by one, saturating
            el_reg <= (fn_reg == FN_TICK && elap_q[ci_reg] != EL_MAX)
                    ? elap_q[ci_reg] + 1'b1 : elap_q[ci_reg];
            gl_reg <= goal_q[ci_reg];
            fu_reg <= fup_q[ci_reg];
            fd_reg <= fdn_q[ci_reg];
            sv_reg <= saved_q[ci_reg];
            dr_reg <= drv_q[ci_reg];
        end
        else
        begin
            st_reg <= st_w; tr_reg <= tr_w; or_reg <= or_w; gl_reg <= gl_w;
            fu_reg <= fu_w; fd_reg <= fd_w; sv_reg <= sv_w; dr_reg <= dr_w;
            ev_reg <= ev_w; rst_reg <= rst_w; save_reg <= save_w;
            el_reg <= el_w;
        end
        if (seq_reg == Q_DIVW_E && !dv_busy)
        begin
            per_q_reg <= dv_quot;
        end
        if (seq_reg == Q_FINAL)
        begin
            p_reg <= pct_trivial(tr_reg, fu_reg) ? pct_trivial_val(tr_reg)
                   : PCT_W'(dv_quot);
        end
        if (seq_reg == Q_LOAD && skip_reg)
        begin
            p_reg <= '0;
        end
    end

    // per-cover storage write back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COVER_COUNT; i++)
            begin
                step_q[i]   <= S_STOPPED;
                travel_q[i] <= '0;
                origin_q[i] <= '0;
                elap_q[i]   <= '0;
                goal_q[i]   <= '0;
                fup_q[i]    <= FULL_RST;
                fdn_q[i]    <= FULL_RST;
                saved_q[i]  <= '0;
                drv_q[i]    <= '0;
            end
        end
        else if (wb_en)
        begin
            step_q[ci_reg]   <= st_reg;
            travel_q[ci_reg] <= tr_reg;
            origin_q[ci_reg] <= or_reg;
            elap_q[ci_reg]   <= el_reg;
            goal_q[ci_reg]   <= gl_reg;
            fup_q[ci_reg]    <= fu_reg;
            fdn_q[ci_reg]    <= fd_reg;
            saved_q[ci_reg]  <= sv_reg;
            drv_q[ci_reg]    <= dr_reg;
        end
    end

    assign pct_reg = p_reg;

    // result register fields
    assign out_cover    = cov_reg;
    assign up_drive     = skip_reg ? 1'b0 : dr_reg[0];
    assign down_drive   = skip_reg ? 1'b0 : dr_reg[1];
    assign percent_open = skip_reg ? '0 : pct_reg;
    assign cover_status = skip_reg ? 3'd0 : (ev_reg ? 3'(rst_reg) : 3'(dstate));
    assign report_event = skip_reg ? 1'b0 : ev_reg;
    assign save_request = skip_reg ? 1'b0 : save_reg;

    logic unused_ok;
    assign unused_ok = ^{dctl, per_q_reg[NUM_W-1:TIME_BITS]};
endmodule

### hw/rtl/tcmc_div.sv
// tcmc_div: shared restoring divider, one quotient bit per cycle
// depends on tcmc_pkg

module tcmc_div #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);
    import tcmc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   r_reg, r_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W+1:0] trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    always_comb
    begin
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        cnt_next = cnt_reg;
        trial    = {r_reg, q_reg[NUM_W-1]} - {2'b00, d_reg};
        if (start)
        begin
            q_next   = num;
            r_next   = '0;
            d_next   = den;
            cnt_next = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!trial[DEN_W+1])
            begin
                r_next = trial[DEN_W:0];
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = q_reg;
endmodule
